@@ rtl/x86_page_table_walker_macros.svh @@
// Assertion macros for the page table walker.
`ifndef X86_PAGE_TABLE_WALKER_MACROS_SVH
`define X86_PAGE_TABLE_WALKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every rising edge outside reset.
`define PTW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define PTW_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PTW_ASSERT(name, prop, msg)
`define PTW_NEVER(name, cond, msg)

`endif

`endif

@@ rtl/x86ptw_pkg.sv @@
// Shared types and constants for the page table walker.
package x86ptw_pkg;

    localparam int DEF_VADDR_BITS   = 48;
    localparam int DEF_PADDR_BITS   = 52;
    localparam int PAGE_OFFSET_BITS = 12;
    localparam int FRAME_BITS       = 40;
    localparam int CFG_IDX_BITS     = 1;
    localparam int CFG_DATA_BITS    = 6;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_LEVELS = 1'b0;
    localparam cfg_idx_t REG_PHYS   = 1'b1;

    localparam logic [2:0] RST_LEVELS = 3'd4;
    localparam logic [5:0] RST_PHYS   = 6'd52;
    localparam logic [5:0] MIN_PHYS   = 6'd32;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_ENTRY   = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_LARGE       = 2'd2;
    localparam logic [1:0] ST_BUSY        = 2'd3;

    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDP  = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_LARGE_BIT   = 7;

    typedef enum logic [1:0] {
        MODE_CLASSIC,
        MODE_PAE,
        MODE_LONG
    } mode_t;

    typedef struct packed {
        logic                  kind;
        logic                  read_wide;
        logic [FRAME_BITS-1:0] frame_number;
        logic [1:0]            status;
        logic [1:0]            fail_level;
    } res_t;

endpackage

@@ rtl/x86ptw_cfg.sv @@
// Configuration registers and decoded paging mode / physical address mask.
module x86ptw_cfg #(
    parameter int PADDR_BITS = x86ptw_pkg::DEF_PADDR_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  x86ptw_pkg::cfg_idx_t                  cfg_index,
    input  logic [x86ptw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output x86ptw_pkg::mode_t                     mode,
    output logic [PADDR_BITS-1:0]                 addr_mask
);
    import x86ptw_pkg::*;

    logic [2:0] levels_reg;
    logic [5:0] phys_reg;
    logic [5:0] phys_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= RST_LEVELS;
            phys_reg   <= RST_PHYS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEVELS: levels_reg <= cfg_data[2:0];
                REG_PHYS:   phys_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (levels_reg <= 3'd2)
            mode = MODE_CLASSIC;
        else if (levels_reg >= 3'd4)
            mode = MODE_LONG;
        else
            mode = MODE_PAE;
    end

    // Clamp to 32..PADDR_BITS, then build a thermometer mask
    always_comb
    begin
        if (phys_reg < MIN_PHYS)
            phys_eff = MIN_PHYS;
        else if (phys_reg > 6'(PADDR_BITS))
            phys_eff = 6'(PADDR_BITS);
        else
            phys_eff = phys_reg;
        for (int i = 0; i < PADDR_BITS; i++)
            addr_mask[i] = (6'(i) < phys_eff);
    end

endmodule

@@ rtl/x86ptw_step.sv @@
// Combinational walk step: request or entry in, next walk state and result out.
module x86ptw_step #(
    parameter int VADDR_BITS = x86ptw_pkg::DEF_VADDR_BITS,
    parameter int PADDR_BITS = x86ptw_pkg::DEF_PADDR_BITS
) (
    input  x86ptw_pkg::mode_t       mode,
    input  logic [PADDR_BITS-1:0]   addr_mask,
    input  logic                    item_valid,
    input  logic                    action,
    input  logic [VADDR_BITS-1:0]   virt_addr,
    input  logic [PADDR_BITS-1:0]   root_addr,
    input  logic [63:0]             entry_data,
    input  logic                    busy,
    input  logic [1:0]              level,
    input  logic [VADDR_BITS-1:0]   held_virt,
    input  logic [PADDR_BITS-1:0]   table_base,
    output logic                    busy_next,
    output logic [1:0]              level_next,
    output logic [VADDR_BITS-1:0]   held_next,
    output logic [PADDR_BITS-1:0]   base_next,
    output logic                    res_valid,
    output x86ptw_pkg::res_t        res,
    output logic [PADDR_BITS-1:0]   res_read_addr
);
    import x86ptw_pkg::*;

    localparam logic [PADDR_BITS-1:0] LOW32_FRAME = PADDR_BITS'(32'hffff_f000);
    localparam logic [PADDR_BITS-1:0] PAGE_ALIGN  = ~PADDR_BITS'(12'hfff);
    localparam logic [PADDR_BITS-1:0] PDPT_ALIGN  = ~PADDR_BITS'(5'h1f);

    logic [PADDR_BITS-1:0] frame_mask;
    logic [PADDR_BITS-1:0] e_frame;
    logic [VADDR_BITS-1:0] tgt_virt;
    logic [PADDR_BITS-1:0] tgt_base;
    logic [1:0]            tgt_level;
    logic [63:0]           v64;
    logic [9:0]            idx;
    logic [12:0]           offset;
    logic                  present;
    logic                  large_map;
    logic                  is_classic;

    assign is_classic = (mode == MODE_CLASSIC);
    assign frame_mask = is_classic ? LOW32_FRAME : (addr_mask & PAGE_ALIGN);
    assign e_frame    = entry_data[PADDR_BITS-1:0] & frame_mask;
    assign present    = entry_data[ENTRY_PRESENT_BIT];
    // PML4 and PAE PDP entries never map large pages
    assign large_map  = entry_data[ENTRY_LARGE_BIT] &&
                        (level == LVL_PD || (level == LVL_PDP && mode == MODE_LONG));

    // Target of the read that follows: a fresh walk or the next level down
    always_comb
    begin
        if (action == ACT_REQUEST)
        begin
            tgt_virt = virt_addr;
            unique case (mode)
                MODE_CLASSIC:
                begin
                    tgt_level = LVL_PD;
                    tgt_base  = root_addr & LOW32_FRAME;
                end
                MODE_PAE:
                begin
                    tgt_level = LVL_PDP;
                    tgt_base  = root_addr & addr_mask & PDPT_ALIGN;
                end
                default:
                begin
                    tgt_level = LVL_PML4;
                    tgt_base  = root_addr & frame_mask;
                end
            endcase
        end
        else
        begin
            tgt_virt  = held_virt;
            tgt_level = level - 2'd1;
            tgt_base  = e_frame;
        end
    end

    always_comb
    begin
        v64 = 64'(tgt_virt);
        if (is_classic)
        begin
            idx = (tgt_level >= LVL_PD) ? v64[31:22] : v64[21:12];
        end
        else
        begin
            case (tgt_level)
                LVL_PML4: idx = {1'b0, v64[47:39]};
                LVL_PDP:  idx = (mode == MODE_PAE) ? {8'b0, v64[31:30]}
                                                   : {1'b0, v64[38:30]};
                LVL_PD:   idx = {1'b0, v64[29:21]};
                default:  idx = {1'b0, v64[20:12]};
            endcase
        end
        offset = is_classic ? {1'b0, idx, 2'b00} : {idx, 3'b000};
    end

    always_comb
    begin
        busy_next     = busy;
        level_next    = level;
        held_next     = held_virt;
        base_next     = table_base;
        res_valid     = 1'b0;
        res           = '0;
        res_read_addr = '0;
        if (item_valid)
        begin
            if (action == ACT_REQUEST && busy)
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_DONE;
                res.status     = ST_BUSY;
                res.fail_level = level;
            end
            else if (action == ACT_ENTRY && busy &&
                     (!present || large_map || level == LVL_PT))
            begin
                busy_next      = 1'b0;
                res_valid      = 1'b1;
                res.kind       = KIND_DONE;
                res.fail_level = level;
                if (!present)
                    res.status = ST_NOT_PRESENT;
                else if (large_map)
                    res.status = ST_LARGE;
                else
                begin
                    res.status       = ST_OK;
                    res.frame_number = FRAME_BITS'(e_frame >> PAGE_OFFSET_BITS);
                end
            end
            else if (action == ACT_REQUEST || busy)
            begin
                busy_next      = 1'b1;
                level_next     = tgt_level;
                held_next      = tgt_virt;
                base_next      = tgt_base;
                res_valid      = 1'b1;
                res.kind       = KIND_READ;
                res.read_wide  = !is_classic;
                res.status     = ST_OK;
                res.fail_level = tgt_level;
                res_read_addr  = tgt_base + PADDR_BITS'(offset);
            end
        end
    end

endmodule

@@ rtl/x86_page_table_walker.sv @@
// Top level of the x86 page table walker: input register, walk state, result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  in       | in_valid / in_stall      | action, virt_addr, root_addr, entry_data
//  out      | out_valid / out_stall    | kind, read_addr, read_wide, frame_number,
//           |                          | status, fail_level
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item per cycle while the result register is not stalled; an item passes the input
// register, then the result register, with the single combinational walk step between them.
// Reset clears the walk state (idle, level 0) and loads paging_levels 4, phys bits 52.
// out_stall holds the result register; the input register then stalls behind it.
// An entry that arrives while idle is consumed and gives no item.
`include "x86_page_table_walker_macros.svh"

module x86_page_table_walker #(
    parameter int VADDR_BITS = x86ptw_pkg::DEF_VADDR_BITS,
    parameter int PADDR_BITS = x86ptw_pkg::DEF_PADDR_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [VADDR_BITS-1:0]                 virt_addr,
    input  logic [PADDR_BITS-1:0]                 root_addr,
    input  logic [63:0]                           entry_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  kind,
    output logic [PADDR_BITS-1:0]                 read_addr,
    output logic                                  read_wide,
    output logic [x86ptw_pkg::FRAME_BITS-1:0]     frame_number,
    output logic [1:0]                            status,
    output logic [1:0]                            fail_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  x86ptw_pkg::cfg_idx_t                  cfg_index,
    input  logic [x86ptw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import x86ptw_pkg::*;

    mode_t                 mode;
    logic [PADDR_BITS-1:0] addr_mask;

    logic                  in_valid_reg;
    logic                  action_reg;
    logic [VADDR_BITS-1:0] virt_reg;
    logic [PADDR_BITS-1:0] root_reg;
    logic [63:0]           entry_reg;

    logic                  walk_busy_reg;
    logic                  walk_busy_next;
    logic [1:0]            walk_level_reg;
    logic [1:0]            walk_level_next;
    logic [VADDR_BITS-1:0] held_virt_reg;
    logic [VADDR_BITS-1:0] held_virt_next;
    logic [PADDR_BITS-1:0] table_base_reg;
    logic [PADDR_BITS-1:0] table_base_next;

    logic                  res_valid;
    res_t                  res;
    logic [PADDR_BITS-1:0] res_read_addr;

    logic                  out_valid_reg;
    res_t                  out_res_reg;
    logic [PADDR_BITS-1:0] out_addr_reg;

    logic                  advance;
    logic                  in_accept;

    x86ptw_cfg #(
        .PADDR_BITS (PADDR_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .addr_mask (addr_mask)
    );

    x86ptw_step #(
        .VADDR_BITS (VADDR_BITS),
        .PADDR_BITS (PADDR_BITS)
    ) u_step (
        .mode          (mode),
        .addr_mask     (addr_mask),
        .item_valid    (in_valid_reg),
        .action        (action_reg),
        .virt_addr     (virt_reg),
        .root_addr     (root_reg),
        .entry_data    (entry_reg),
        .busy          (walk_busy_reg),
        .level         (walk_level_reg),
        .held_virt     (held_virt_reg),
        .table_base    (table_base_reg),
        .busy_next     (walk_busy_next),
        .level_next    (walk_level_next),
        .held_next     (held_virt_next),
        .base_next     (table_base_next),
        .res_valid     (res_valid),
        .res           (res),
        .res_read_addr (res_read_addr)
    );

    // Held item moves on when the result register is empty or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            virt_reg   <= virt_addr;
            root_reg   <= root_addr;
            entry_reg  <= entry_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg  <= 1'b0;
            walk_level_reg <= LVL_PT;
            held_virt_reg  <= '0;
            table_base_reg <= '0;
        end
        else if (advance)
        begin
            walk_busy_reg  <= walk_busy_next;
            walk_level_reg <= walk_level_next;
            held_virt_reg  <= held_virt_next;
            table_base_reg <= table_base_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg  <= res;
            out_addr_reg <= res_read_addr;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign read_addr    = out_addr_reg;
    assign read_wide    = out_res_reg.read_wide;
    assign frame_number = out_res_reg.frame_number;
    assign status       = out_res_reg.status;
    assign fail_level   = out_res_reg.fail_level;

    `PTW_ASSERT(a_read_keeps_busy, advance && res_valid && res.kind == KIND_READ |=> walk_busy_reg, "read request issued but walker not busy")
    `PTW_ASSERT(a_busy_reply_keeps_walk, advance && res_valid && res.status == ST_BUSY |=> walk_busy_reg && walk_level_reg == $past(walk_level_reg), "busy reply disturbed the walk")
    `PTW_NEVER(a_read_item_clean, out_valid_reg && out_res_reg.kind == KIND_READ && (out_res_reg.status != ST_OK || out_res_reg.frame_number != '0), "read item carries status or frame")
    `PTW_NEVER(a_done_item_no_addr, out_valid_reg && out_res_reg.kind == KIND_DONE && (out_addr_reg != '0 || out_res_reg.read_wide), "finished item carries a read address")

endmodule

@@ sim/x86_page_table_walker_checker.sv @@
`timescale 1ns / 100ps
// Walk predictor and result checker for the x86 page table walker.
module x86_page_table_walker_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic                                    action,
    input  logic [x86ptw_pkg::DEF_VADDR_BITS-1:0]   virt_addr,
    input  logic [x86ptw_pkg::DEF_PADDR_BITS-1:0]   root_addr,
    input  logic [63:0]                             entry_data,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic                                    kind,
    input  logic [x86ptw_pkg::DEF_PADDR_BITS-1:0]   read_addr,
    input  logic                                    read_wide,
    input  logic [x86ptw_pkg::FRAME_BITS-1:0]       frame_number,
    input  logic [1:0]                              status,
    input  logic [1:0]                              fail_level,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  x86ptw_pkg::cfg_idx_t                    cfg_index,
    input  logic [x86ptw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output int                                      fail_count,
    output int                                      pending
);
    import x86ptw_pkg::*;

    typedef struct packed {
        logic                       kind;
        logic [DEF_PADDR_BITS-1:0]  read_addr;
        logic                       read_wide;
        logic [FRAME_BITS-1:0]      frame_number;
        logic [1:0]                 status;
        logic [1:0]                 fail_level;
    } walk_result_t;

    walk_result_t walk_results_due[$];

    logic [2:0]                 levels_reg;
    logic [5:0]                 phys_reg;
    logic                       walking;
    logic [1:0]                 cur_level;
    logic [DEF_VADDR_BITS-1:0]  held_va;
    logic [63:0]                next_table;

    function automatic mode_t walk_mode();
        if (levels_reg <= 3'd2)
            return MODE_CLASSIC;
        if (levels_reg >= 3'd4)
            return MODE_LONG;
        return MODE_PAE;
    endfunction

    function automatic logic [63:0] phys_mask();
        int pb;
        pb = int'(phys_reg);
        if (pb < int'(MIN_PHYS))
            pb = int'(MIN_PHYS);
        if (pb > DEF_PADDR_BITS)
            pb = DEF_PADDR_BITS;
        return (64'd1 << pb) - 64'd1;
    endfunction

    function automatic logic [63:0] frame_mask();
        if (walk_mode() == MODE_CLASSIC)
            return 64'h0000_0000_ffff_f000;
        return phys_mask() & ~64'hfff;
    endfunction

    // Read request for the entry of the current level
    function automatic walk_result_t entry_read();
        walk_result_t r;
        logic [63:0]  idx;
        logic [63:0]  addr;
        mode_t        m;
        m = walk_mode();
        if (m == MODE_CLASSIC)
        begin
            idx = (cur_level >= LVL_PD) ? 64'(held_va[31:22]) : 64'(held_va[21:12]);
            addr = next_table + (idx << 2);
        end
        else
        begin
            case (cur_level)
                LVL_PML4: idx = 64'(held_va[47:39]);
                LVL_PDP:  idx = (m == MODE_PAE) ? 64'(held_va[31:30]) : 64'(held_va[38:30]);
                LVL_PD:   idx = 64'(held_va[29:21]);
                default:  idx = 64'(held_va[20:12]);
            endcase
            addr = next_table + (idx << 3);
        end
        r = '0;
        r.kind = KIND_READ;
        r.read_addr = addr[DEF_PADDR_BITS-1:0];
        r.read_wide = (m != MODE_CLASSIC);
        r.status = ST_OK;
        r.fail_level = cur_level;
        return r;
    endfunction

    function automatic walk_result_t walk_done(input logic [1:0] st, input logic [1:0] lvl,
                                               input logic [FRAME_BITS-1:0] frame);
        walk_result_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.frame_number = frame;
        r.status = st;
        r.fail_level = lvl;
        return r;
    endfunction

    task automatic walk_step(input logic act, input logic [DEF_VADDR_BITS-1:0] va,
                             input logic [DEF_PADDR_BITS-1:0] ra, input logic [63:0] ed);
        logic [63:0] e;
        logic [63:0] fr;
        mode_t       m;
        m = walk_mode();
        if (act == ACT_REQUEST)
        begin
            if (walking)
            begin
                // walk in progress carries on untouched
                walk_results_due.push_back(walk_done(ST_BUSY, cur_level, '0));
            end
            else
            begin
                held_va = va;
                walking = 1'b1;
                case (m)
                    MODE_LONG:
                    begin
                        cur_level = LVL_PML4;
                        next_table = 64'(ra) & frame_mask();
                    end
                    MODE_PAE:
                    begin
                        cur_level = LVL_PDP;
                        next_table = 64'(ra) & phys_mask() & ~64'h1f;
                    end
                    default:
                    begin
                        cur_level = LVL_PD;
                        next_table = 64'(ra) & 64'h0000_0000_ffff_f000;
                    end
                endcase
                walk_results_due.push_back(entry_read());
            end
        end
        else if (walking)
        begin
            e = ed;
            if (m == MODE_CLASSIC)
                e[63:32] = '0;
            if (!e[ENTRY_PRESENT_BIT])
            begin
                walking = 1'b0;
                walk_results_due.push_back(walk_done(ST_NOT_PRESENT, cur_level, '0));
            end
            else if (e[ENTRY_LARGE_BIT] &&
                     (cur_level == LVL_PD || (cur_level == LVL_PDP && m == MODE_LONG)))
            begin
                walking = 1'b0;
                walk_results_due.push_back(walk_done(ST_LARGE, cur_level, '0));
            end
            else if (cur_level == LVL_PT)
            begin
                walking = 1'b0;
                fr = (e & frame_mask()) >> PAGE_OFFSET_BITS;
                walk_results_due.push_back(walk_done(ST_OK, LVL_PT, fr[FRAME_BITS-1:0]));
            end
            else
            begin
                next_table = e & frame_mask();
                cur_level = cur_level - 2'd1;
                walk_results_due.push_back(entry_read());
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t want;
        if (!rst_n)
        begin
            levels_reg = RST_LEVELS;
            phys_reg = RST_PHYS;
            walking = 1'b0;
            cur_level = LVL_PT;
            held_va = '0;
            next_table = '0;
            walk_results_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // outputs first: an item accepted this edge cannot have its result yet
            if (out_valid && !out_stall)
            begin
                if (walk_results_due.size() == 0)
                begin
                    $display("%0t: unexpected item kind %0d addr %h frame %h status %0d level %0d",
                             $time, kind, read_addr, frame_number, status, fail_level);
                    fail_count++;
                end
                else
                begin
                    want = walk_results_due.pop_front();
                    if (want.kind !== kind || want.read_addr !== read_addr ||
                        want.read_wide !== read_wide || want.frame_number !== frame_number ||
                        want.status !== status || want.fail_level !== fail_level)
                    begin
                        $display("%0t: expected kind %0d addr %h wide %0d frame %h st %0d lvl %0d",
                                 $time, want.kind, want.read_addr, want.read_wide,
                                 want.frame_number, want.status, want.fail_level);
                        $display("%0t: actual   kind %0d addr %h wide %0d frame %h st %0d lvl %0d",
                                 $time, kind, read_addr, read_wide, frame_number, status,
                                 fail_level);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LEVELS)
                    levels_reg = cfg_data[2:0];
                else if (cfg_index == REG_PHYS)
                    phys_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                walk_step(action, virt_addr, root_addr, entry_data);
            pending = walk_results_due.size();
        end
    end

endmodule

@@ sim/x86_page_table_walker_tb.sv @@
`timescale 1ns / 100ps
// Stimulus, clocking and verdict for the x86 page table walker testbench.
module x86_page_table_walker_tb;
    import x86ptw_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int BLOCK_ITEMS = 45;
    localparam int BLOCKS      = 9;

    // per-block register settings, block 0 in the low bits
    localparam logic [26:0] LEVEL_PLAN = {3'd4, 3'd6, 3'd5, 3'd1, 3'd7, 3'd0, 3'd2, 3'd3, 3'd4};
    localparam logic [53:0] PHYS_PLAN  = {6'd33, 6'd45, 6'd51, 6'd36, 6'd63, 6'd0, 6'd40,
                                          6'd32, 6'd52};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       action = ACT_REQUEST;
    logic [DEF_VADDR_BITS-1:0]  virt_addr = '0;
    logic [DEF_PADDR_BITS-1:0]  root_addr = '0;
    logic [63:0]                entry_data = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       kind;
    logic [DEF_PADDR_BITS-1:0]  read_addr;
    logic                       read_wide;
    logic [FRAME_BITS-1:0]      frame_number;
    logic [1:0]                 status;
    logic [1:0]                 fail_level;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_idx_t                   cfg_index = REG_LEVELS;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

    int         fail_count;
    int         pending;
    int         tx_idle_pct = 33;
    int         rx_idle_pct = 51;
    int         items_sent = 0;
    int         hold_req = 0;
    int         hold_ack = 0;
    int         cycles = 0;
    logic [2:0] levels_now = RST_LEVELS;

    x86_page_table_walker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .virt_addr    (virt_addr),
        .root_addr    (root_addr),
        .entry_data   (entry_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .read_addr    (read_addr),
        .read_wide    (read_wide),
        .frame_number (frame_number),
        .status       (status),
        .fail_level   (fail_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    x86_page_table_walker_checker walk_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .virt_addr    (virt_addr),
        .root_addr    (root_addr),
        .entry_data   (entry_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .read_addr    (read_addr),
        .read_wide    (read_wide),
        .frame_number (frame_number),
        .status       (status),
        .fail_level   (fail_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    always
    begin
        @(negedge clk);
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            out_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
        end
        out_stall = ($urandom_range(0, 99) < rx_idle_pct);
    end

    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[x86_page_table_walker] ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic act, input logic [63:0] va, input logic [63:0] ra,
                             input logic [63:0] ed);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action = act;
        virt_addr = va[DEF_VADDR_BITS-1:0];
        root_addr = ra[DEF_PADDR_BITS-1:0];
        entry_data = ed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
    endtask

    task automatic send_entry(input logic [63:0] ed);
        send_item(ACT_ENTRY, rand64(), rand64(), ed);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_mode(input logic [2:0] lv, input logic [5:0] pb);
        write_reg(REG_LEVELS, {3'b000, lv});
        write_reg(REG_PHYS, pb);
        levels_now = lv;
    endtask

    // drain, then cover an ignored entry still in the pipe
    task automatic settle();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mostly well-formed walk; stops once an entry ends it
    task automatic random_walk();
        int          depth;
        int          lvl;
        logic [63:0] e;
        depth = (levels_now <= 3'd2) ? 2 : ((levels_now >= 3'd4) ? 4 : 3);
        send_item(ACT_REQUEST, rand64(), rand64(), rand64());
        for (int j = 0; j < depth; j++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_REQUEST, rand64(), rand64(), rand64());
            e = rand64();
            e[ENTRY_PRESENT_BIT] = ($urandom_range(0, 11) != 0);
            e[ENTRY_LARGE_BIT] = ($urandom_range(0, 6) == 0);
            send_entry(e);
            lvl = depth - 1 - j;
            if (!e[ENTRY_PRESENT_BIT] ||
                (e[ENTRY_LARGE_BIT] && (lvl == 1 || (lvl == 2 && depth == 4))))
                break;
        end
    endtask

    initial
    begin
        int block_end;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // long mode at reset settings
        send_entry('1);
        send_item(ACT_REQUEST, '1, '1, '0);
        send_entry('1);
        send_item(ACT_REQUEST, '0, '0, '1);
        send_entry(64'hffff_ffff_ffff_ff7f);
        send_entry(64'hffff_ffff_ffff_ff7f);
        send_entry('1);
        send_item(ACT_REQUEST, '0, '0, '0);
        send_entry('0);
        send_item(ACT_REQUEST, rand64(), rand64(), rand64());
        send_entry(64'h1);
        send_entry(64'h81);
        send_item(ACT_REQUEST, rand64(), rand64(), rand64());
        send_entry(64'h1);
        send_entry(64'h1);
        send_entry(64'h81);

        // PAE: large bit of the PDP entry is not looked at
        settle();
        set_mode(3'd3, MIN_PHYS);
        send_item(ACT_REQUEST, '1, '1, '0);
        send_entry(64'hff);
        send_entry(64'hffff_ffff_ffff_ff7f);
        send_entry('1);

        // classic: upper half of the entry is dropped
        settle();
        set_mode(3'd2, RST_PHYS);
        send_item(ACT_REQUEST, '1, '1, '0);
        send_entry(64'hffff_ffff_0000_0000);
        send_item(ACT_REQUEST, rand64(), rand64(), rand64());
        send_entry(64'h81);
        send_item(ACT_REQUEST, rand64(), rand64(), rand64());
        send_entry(64'hffff_ffff_ffff_ff7f);
        send_entry('1);

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            settle();
            set_mode(LEVEL_PLAN[3*blk +: 3], PHYS_PLAN[6*blk +: 6]);
            if (blk < 3)
            begin
                tx_idle_pct = 33;
                rx_idle_pct = 51;
            end
            else if (blk < 6)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 33;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (blk == 7)
                hold_req++;
            block_end = items_sent + BLOCK_ITEMS;
            while (items_sent < block_end)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_item(($urandom_range(0, 1) != 0), rand64(), rand64(), rand64());
                else
                    random_walk();
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[x86_page_table_walker] OK");
        else
            $display("[x86_page_table_walker] ERROR");
        $finish;
    end

endmodule
